### hdl/assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");
`else
`define AST_IMPLIES(lbl, clk, rst_n, ante, cons)
`define AST_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hdl/tli_pkg.sv
package tli_pkg;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_INTERP = 2'd0,
		ST_LOW    = 2'd1,
		ST_HIGH   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		RA_FIRST,
		RA_LAST,
		RA_MID,
		RA_LEFT,
		RA_RIGHT
	} addr_sel_t;

	typedef enum logic [1:0] {
		OS_EMPTY,
		OS_ROW,
		OS_BLEND
	} out_src_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CHECK,
		S_CMP_FIRST,
		S_CMP_LAST,
		S_SRCH,
		S_SRCH_CMP,
		S_LD_LEFT,
		S_LD_RIGHT,
		S_PREP,
		S_DIV_CHK,
		S_DIV,
		S_MUL_RE,
		S_ADD_RE,
		S_MUL_IM,
		S_ADD_IM,
		S_OUT_EMPTY,
		S_OUT_LOW,
		S_OUT_HIGH,
		S_OUT_BLEND
	} state_t;

	typedef struct packed {
		logic      capture;
		logic      mem_wr;
		logic      rd_en;
		addr_sel_t rd_sel;
		logic      srch_init;
		logic      srch_step;
		logic      ld_left;
		logic      ld_right;
		logic      div_init;
		logic      div_chk;
		logic      div_step;
		logic      mul_en;
		logic      mul_im;
		logic      acc_en;
		logic      out_ld;
		out_src_t  out_src;
		status_t   out_status;
	} cmd_t;

	typedef struct packed {
		logic n_zero;
		logic q_le_rd;
		logic q_ge_rd;
		logic srch_done;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

### hdl/tli_ctrl.sv
module tli_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_op,
	input  tli_pkg::sts_t   sts,
	output tli_pkg::cmd_t   cmd,
	output logic            in_ready
);

	tli_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tli_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.rd_sel     = tli_pkg::RA_FIRST;
		cmd.out_src    = tli_pkg::OS_EMPTY;
		cmd.out_status = tli_pkg::ST_INTERP;
		in_ready       = 1'b0;
		unique case (state_q)
			tli_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == tli_pkg::OP_LOAD) begin
						cmd.mem_wr = 1'b1;
					end else begin
						cmd.capture = 1'b1;
						state_d     = tli_pkg::S_CHECK;
					end
				end
			end
			tli_pkg::S_CHECK: begin
				if (sts.n_zero) begin
					state_d = tli_pkg::S_OUT_EMPTY;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = tli_pkg::RA_FIRST;
					state_d    = tli_pkg::S_CMP_FIRST;
				end
			end
			tli_pkg::S_CMP_FIRST: begin
				if (sts.q_le_rd) begin
					state_d = tli_pkg::S_OUT_LOW;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = tli_pkg::RA_LAST;
					state_d    = tli_pkg::S_CMP_LAST;
				end
			end
			tli_pkg::S_CMP_LAST: begin
				if (sts.q_ge_rd) begin
					state_d = tli_pkg::S_OUT_HIGH;
				end else begin
					cmd.srch_init = 1'b1;
					state_d       = tli_pkg::S_SRCH;
				end
			end
			tli_pkg::S_SRCH: begin
				cmd.rd_en = 1'b1;
				if (sts.srch_done) begin
					cmd.rd_sel = tli_pkg::RA_LEFT;
					state_d    = tli_pkg::S_LD_LEFT;
				end else begin
					cmd.rd_sel = tli_pkg::RA_MID;
					state_d    = tli_pkg::S_SRCH_CMP;
				end
			end
			tli_pkg::S_SRCH_CMP: begin
				cmd.srch_step = 1'b1;
				state_d       = tli_pkg::S_SRCH;
			end
			tli_pkg::S_LD_LEFT: begin
				cmd.ld_left = 1'b1;
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = tli_pkg::RA_RIGHT;
				state_d     = tli_pkg::S_LD_RIGHT;
			end
			tli_pkg::S_LD_RIGHT: begin
				cmd.ld_right = 1'b1;
				state_d      = tli_pkg::S_PREP;
			end
			tli_pkg::S_PREP: begin
				cmd.div_init = 1'b1;
				state_d      = tli_pkg::S_DIV_CHK;
			end
			tli_pkg::S_DIV_CHK: begin
				cmd.div_chk = 1'b1;
				state_d     = tli_pkg::S_DIV;
			end
			tli_pkg::S_DIV: begin
				if (sts.div_done) begin
					state_d = tli_pkg::S_MUL_RE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			tli_pkg::S_MUL_RE: begin
				cmd.mul_en = 1'b1;
				state_d    = tli_pkg::S_ADD_RE;
			end
			tli_pkg::S_ADD_RE: begin
				cmd.acc_en = 1'b1;
				state_d    = tli_pkg::S_MUL_IM;
			end
			tli_pkg::S_MUL_IM: begin
				cmd.mul_en = 1'b1;
				cmd.mul_im = 1'b1;
				state_d    = tli_pkg::S_ADD_IM;
			end
			tli_pkg::S_ADD_IM: begin
				cmd.acc_en = 1'b1;
				cmd.mul_im = 1'b1;
				state_d    = tli_pkg::S_OUT_BLEND;
			end
			tli_pkg::S_OUT_EMPTY: begin
				cmd.out_src    = tli_pkg::OS_EMPTY;
				cmd.out_status = tli_pkg::ST_EMPTY;
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = tli_pkg::S_IDLE;
				end
			end
			tli_pkg::S_OUT_LOW: begin
				cmd.out_src    = tli_pkg::OS_ROW;
				cmd.out_status = tli_pkg::ST_LOW;
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = tli_pkg::S_IDLE;
				end
			end
			tli_pkg::S_OUT_HIGH: begin
				cmd.out_src    = tli_pkg::OS_ROW;
				cmd.out_status = tli_pkg::ST_HIGH;
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = tli_pkg::S_IDLE;
				end
			end
			tli_pkg::S_OUT_BLEND: begin
				cmd.out_src    = tli_pkg::OS_BLEND;
				cmd.out_status = tli_pkg::ST_INTERP;
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = tli_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tli_pkg::S_IDLE;
			end
		endcase
	end

endmodule

### hdl/tli_datapath.sv
module tli_datapath #(
	parameter int TABLE_DEPTH   = 256,
	parameter int FRACTION_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [8:0]          cfg_wdata,
	input  logic [7:0]          in_index,
	input  logic signed [31:0]  in_x,
	input  logic signed [31:0]  in_yre,
	input  logic signed [31:0]  in_yim,
	input  logic signed [31:0]  in_q,
	input  tli_pkg::cmd_t       cmd,
	output tli_pkg::sts_t       sts,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [31:0]         out_re,
	output logic [31:0]         out_im,
	output logic [1:0]          out_status
);

	localparam int AW   = $clog2(TABLE_DEPTH);
	localparam int CW   = $clog2(TABLE_DEPTH + 1);
	localparam int FB   = FRACTION_BITS;
	localparam int CNTW = $clog2(FB + 1);
	localparam int PW   = 33 + FB + 1;

	logic [95:0]             mem [TABLE_DEPTH];
	logic [95:0]             rdata_q;
	logic [AW-1:0]           rd_addr;
	logic                    idx_ok;

	logic [8:0]              pin_q;
	logic signed [31:0]      q_q;
	logic [CW-1:0]           n_q, lo_q, hi_q;
	logic [CW-1:0]           mid, last, right_c, left_c;

	logic signed [31:0]      xl_q, xr_q, ylre_q, ylim_q, yrre_q, yrim_q;
	logic [31:0]             rem_q, den_q;
	logic [FB-1:0]           frac_q, frac;
	logic [CNTW-1:0]         cnt_q;
	logic                    sat_q;
	logic [32:0]             dnum, dden, r2;
	logic                    r2_ge;

	logic signed [PW-1:0]    prod_q, prod_sh;
	logic signed [31:0]      yl_sel, yr_sel, blend;
	logic signed [32:0]      ydiff;
	logic signed [31:0]      res_re_q, res_im_q;

	logic                    out_valid_q;
	logic [31:0]             out_re_q, out_im_q;
	tli_pkg::status_t        out_status_q;

	logic signed [31:0]      rd_x;

	assign rd_x   = rdata_q[31:0];
	assign idx_ok = 32'(in_index) < TABLE_DEPTH;
	assign mid    = lo_q + ((hi_q - lo_q) >> 1);
	assign last   = n_q - CW'(1);

	always_comb begin
		if (lo_q == '0) begin
			right_c = CW'(1);
		end else if (lo_q > last) begin
			right_c = last;
		end else begin
			right_c = lo_q;
		end
		left_c = right_c - CW'(1);
	end

	always_comb begin
		unique case (cmd.rd_sel)
			tli_pkg::RA_FIRST: rd_addr = '0;
			tli_pkg::RA_LAST:  rd_addr = AW'(last);
			tli_pkg::RA_MID:   rd_addr = AW'(mid);
			tli_pkg::RA_LEFT:  rd_addr = AW'(left_c);
			tli_pkg::RA_RIGHT: rd_addr = AW'(right_c);
			default:           rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_wr && idx_ok) begin
			mem[AW'(in_index)] <= {in_yim, in_yre, in_x};
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign dnum  = {q_q[31], q_q} - {xl_q[31], xl_q};
	assign dden  = {xr_q[31], xr_q} - {xl_q[31], xl_q};
	assign r2    = {rem_q, 1'b0};
	assign r2_ge = r2 >= {1'b0, den_q};
	assign frac  = sat_q ? '1 : frac_q;

	assign yl_sel  = cmd.mul_im ? ylim_q : ylre_q;
	assign yr_sel  = cmd.mul_im ? yrim_q : yrre_q;
	assign ydiff   = {yr_sel[31], yr_sel} - {yl_sel[31], yl_sel};
	assign prod_sh = prod_q >>> FB;
	assign blend   = yl_sel + $signed(prod_sh[31:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_q       <= '0;
			n_q         <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			cnt_q       <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				pin_q <= cfg_wdata;
			end
			if (cmd.capture) begin
				n_q <= (32'(pin_q) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(pin_q);
			end
			if (cmd.srch_init) begin
				lo_q <= '0;
				hi_q <= n_q;
			end else if (cmd.srch_step) begin
				if (rd_x > q_q) begin
					hi_q <= mid;
				end else begin
					lo_q <= mid + CW'(1);
				end
			end
			if (cmd.div_init) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CNTW'(1);
			end
			if (cmd.div_chk) begin
				sat_q <= rem_q >= den_q;
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			q_q <= in_q;
		end
		if (cmd.ld_left) begin
			xl_q   <= rdata_q[31:0];
			ylre_q <= rdata_q[63:32];
			ylim_q <= rdata_q[95:64];
		end
		if (cmd.ld_right) begin
			xr_q   <= rdata_q[31:0];
			yrre_q <= rdata_q[63:32];
			yrim_q <= rdata_q[95:64];
		end
		if (cmd.div_init) begin
			rem_q  <= (q_q > xl_q) ? dnum[31:0] : '0;
			den_q  <= (xr_q > xl_q) ? dden[31:0] : 32'd1;
			frac_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= r2_ge ? 32'(r2 - {1'b0, den_q}) : r2[31:0];
			frac_q <= {frac_q[FB-2:0], r2_ge};
		end
		if (cmd.mul_en) begin
			prod_q <= PW'(ydiff * $signed({1'b0, frac}));
		end
		if (cmd.acc_en) begin
			if (cmd.mul_im) begin
				res_im_q <= blend;
			end else begin
				res_re_q <= blend;
			end
		end
		if (cmd.out_ld) begin
			out_status_q <= cmd.out_status;
			unique case (cmd.out_src)
				tli_pkg::OS_EMPTY: begin
					out_re_q <= '0;
					out_im_q <= '0;
				end
				tli_pkg::OS_ROW: begin
					out_re_q <= rdata_q[63:32];
					out_im_q <= rdata_q[95:64];
				end
				tli_pkg::OS_BLEND: begin
					out_re_q <= res_re_q;
					out_im_q <= res_im_q;
				end
				default: begin
					out_re_q <= '0;
					out_im_q <= '0;
				end
			endcase
		end
	end

	assign sts.n_zero    = n_q == '0;
	assign sts.q_le_rd   = q_q <= rd_x;
	assign sts.q_ge_rd   = q_q >= rd_x;
	assign sts.srch_done = lo_q >= hi_q;
	assign sts.div_done  = cnt_q == CNTW'(FB);
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_re     = out_re_q;
	assign out_im     = out_im_q;
	assign out_status = out_status_q;

endmodule

### hdl/table_linear_interpolator_top.sv
// Channel  Dir  Width   Contents
// s_*      in   136+1   tdata: point_index, point_x, point_y_real, point_y_imag, query_x
// m_*      out  64+2    tdata: value_real, value_imag; tuser: status
// cfg_*    in   9       points_in_use
//
// A query reports an empty table, clamps low or high at the first or last point, or interpolates;
// an interpolating query runs a search loop on the single table read port and then a bit-serial
// fraction divider. One item is in work at a time.
// Reset clears control state only; table entries are undefined until loaded.
// A stalled result waits in the output register while the next item is taken.
`include "assert_macros.svh"

module table_linear_interpolator_top #(
	parameter int TABLE_DEPTH   = 256,
	parameter int FRACTION_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// point_index[7:0], point_x[39:8], point_y_real[71:40], point_y_imag[103:72],
	// query_x[135:104]
	input  logic [135:0] s_tdata,
	// opcode[0]
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// value_real[31:0], value_imag[63:32]
	output logic [63:0]  m_tdata,
	// status[1:0]
	output logic [1:0]   m_tuser,
	input  logic         cfg_we,
	input  logic [8:0]   cfg_wdata
);

	tli_pkg::cmd_t cmd;
	tli_pkg::sts_t sts;
	logic          ctrl_valid;

	assign ctrl_valid = s_tvalid;

	tli_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (ctrl_valid),
		.in_op    (s_tuser[0]),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (s_tready)
	);

	tli_datapath #(
		.TABLE_DEPTH   (TABLE_DEPTH),
		.FRACTION_BITS (FRACTION_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_index   (s_tdata[7:0]),
		.in_x       (s_tdata[39:8]),
		.in_yre     (s_tdata[71:40]),
		.in_yim     (s_tdata[103:72]),
		.in_q       (s_tdata[135:104]),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_re     (m_tdata[31:0]),
		.out_im     (m_tdata[63:32]),
		.out_status (m_tuser)
	);

	`AST_IMPLIES(a_wr_on_beat, clk, arst_n, cmd.mem_wr, s_tvalid && s_tready && !s_tuser[0])
	`AST_NEXT(a_load_one_cycle, clk, arst_n, s_tvalid && s_tready && !s_tuser[0], s_tready)
	`AST_NEXT(a_query_busy, clk, arst_n, s_tvalid && s_tready && s_tuser[0], !s_tready)
	`AST_IMPLIES(a_no_overwrite, clk, arst_n, cmd.out_ld, !m_tvalid || m_tready)

endmodule
